// ----- hdl/quoted_string_escape_decoder_assert.svh -----
// assertion macros shared by the decoder
`ifndef QUOTED_STRING_ESCAPE_DECODER_ASSERT_SVH
`define QUOTED_STRING_ESCAPE_DECODER_ASSERT_SVH

// condition holds in the same cycle
`define QSED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the next cycle
`define QSED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/qsed_pkg.sv -----
`default_nettype none

package qsed_pkg;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_BODY  = 3'd1,
      PH_ESC   = 3'd2,
      PH_HEX1  = 3'd3,
      PH_HEX2  = 3'd4,
      PH_OCT   = 3'd5,
      PH_DONE  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_NOQ   = 2'd2,
      KIND_EARLY = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
   } rsp_type;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWX   = 8'h78;
   localparam logic [7:0] CHAR_UPX    = 8'h58;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_ONE    = 8'h31;
   localparam logic [7:0] CHAR_SEVEN  = 8'h37;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LOWA   = 8'h61;
   localparam logic [7:0] CHAR_LOWF   = 8'h66;
   localparam logic [7:0] CHAR_UPA    = 8'h41;
   localparam logic [7:0] CHAR_UPF    = 8'h46;
   localparam logic [7:0] CHAR_LOWN   = 8'h6E;
   localparam logic [7:0] CHAR_LOWT   = 8'h74;
   localparam logic [7:0] CHAR_LOWR   = 8'h72;
   localparam logic [7:0] CHAR_LOWB   = 8'h62;
   localparam logic [7:0] CHAR_LOWV   = 8'h76;
   localparam logic [7:0] CHAR_CASE   = 8'h20;

   localparam logic [7:0] CODE_NL  = 8'h0A;
   localparam logic [7:0] CODE_TAB = 8'h09;
   localparam logic [7:0] CODE_CR  = 8'h0D;
   localparam logic [7:0] CODE_BEL = 8'h07;
   localparam logic [7:0] CODE_BS  = 8'h08;
   localparam logic [7:0] CODE_FF  = 8'h0C;
   localparam logic [7:0] CODE_VT  = 8'h0B;
   localparam logic [7:0] CODE_NUL = 8'h00;

   // {is_digit, value}
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] res;
      res = 5'd0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         res = {1'b1, b[3:0]};
      end else if ((b >= CHAR_LOWA && b <= CHAR_LOWF) || (b >= CHAR_UPA && b <= CHAR_UPF)) begin
         res = {1'b1, 4'(b[2:0] + 4'd9)};
      end
      return res;
   endfunction

   function automatic logic [7:0] simple_escape(input logic [7:0] b);
      logic [7:0] res;
      logic [7:0] low;
      low = b | CHAR_CASE;
      res = b;
      case (low)
         CHAR_LOWN: res = CODE_NL;
         CHAR_LOWT: res = CODE_TAB;
         CHAR_LOWR: res = CODE_CR;
         CHAR_LOWA: res = CODE_BEL;
         CHAR_LOWB: res = CODE_BS;
         CHAR_LOWF: res = CODE_FF;
         CHAR_LOWV: res = CODE_VT;
         default:   res = b;
      endcase
      if (b == CHAR_ZERO) begin
         res = CODE_NUL;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/quoted_string_escape_decoder.sv -----
// channel  | ports                        | payload
// ---------+------------------------------+-------------------------------
// request  | req_valid, req_stall, req_data | in_byte, in_last
// response | rsp_valid, rsp_stall, rsp_data | out_byte, kind
//
// one byte is taken per cycle while req_stall is low; its result, if any,
// is registered the cycle after, in the output or the skid register.
// the cost per byte is set by the parse phase update, a single small step.
// reset (synchronous) returns to awaiting an opening quote, both slots empty.
// a stalled result is held in the output register, the next one in a skid
// register; req_stall rises only while the skid register is occupied.
`default_nettype none

`include "quoted_string_escape_decoder_assert.svh"

module quoted_string_escape_decoder (
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  logic              req_valid,
   output       logic              req_stall,
   input  wire  qsed_pkg::req_type req_data,
   output       logic              rsp_valid,
   input  wire  logic              rsp_stall,
   output       qsed_pkg::rsp_type rsp_data
);

   qsed_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          partial_ff, partial_in;

   logic              out_valid_ff, out_valid_in;
   qsed_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   qsed_pkg::rsp_type skid_data_ff, skid_data_in;

   logic              accept;
   logic              out_free;
   logic              emit;
   logic              closed;
   qsed_pkg::kind_type kind;
   logic [7:0]        val;
   logic [7:0]        b;
   logic [4:0]        hex;
   logic              is_oct;
   logic              is_oct_lead;
   logic              is_x;
   qsed_pkg::rsp_type result;

   assign b           = req_data.in_byte;
   assign hex         = qsed_pkg::hex_value(b);
   assign is_oct      = (b >= qsed_pkg::CHAR_ZERO) && (b <= qsed_pkg::CHAR_SEVEN);
   assign is_oct_lead = (b >= qsed_pkg::CHAR_ONE) && (b <= qsed_pkg::CHAR_SEVEN);
   assign is_x        = (b == qsed_pkg::CHAR_LOWX) || (b == qsed_pkg::CHAR_UPX);

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // next phase and partial escape value
   always_comb begin
      phase_in   = phase_ff;
      partial_in = partial_ff;
      case (phase_ff)
         qsed_pkg::PH_START: begin
            phase_in = (b == qsed_pkg::CHAR_QUOTE) ? qsed_pkg::PH_BODY : qsed_pkg::PH_DONE;
         end
         qsed_pkg::PH_BODY: begin
            if (b == qsed_pkg::CHAR_QUOTE) begin
               phase_in = qsed_pkg::PH_DONE;
            end else if (b == qsed_pkg::CHAR_BSLASH) begin
               phase_in = qsed_pkg::PH_ESC;
            end
         end
         qsed_pkg::PH_ESC: begin
            if (is_x) begin
               phase_in = qsed_pkg::PH_HEX1;
            end else if (is_oct_lead) begin
               partial_in = {1'b0, b[2:0]};
               phase_in   = qsed_pkg::PH_OCT;
            end else begin
               phase_in = qsed_pkg::PH_BODY;
            end
         end
         qsed_pkg::PH_HEX1: begin
            if (hex[4]) begin
               partial_in = hex[3:0];
               phase_in   = qsed_pkg::PH_HEX2;
            end else begin
               phase_in = qsed_pkg::PH_BODY;
            end
         end
         qsed_pkg::PH_HEX2: phase_in = qsed_pkg::PH_BODY;
         qsed_pkg::PH_OCT:  phase_in = qsed_pkg::PH_BODY;
         default:           phase_in = phase_ff;
      endcase
      if (req_data.in_last) begin
         phase_in   = qsed_pkg::PH_START;
         partial_in = 4'd0;
      end
   end

   // result of this byte
   always_comb begin
      emit   = 1'b0;
      closed = 1'b0;
      kind   = qsed_pkg::KIND_DATA;
      val    = 8'd0;
      case (phase_ff)
         qsed_pkg::PH_START: begin
            if (b != qsed_pkg::CHAR_QUOTE) begin
               emit   = 1'b1;
               kind   = qsed_pkg::KIND_NOQ;
               closed = 1'b1;
            end
         end
         qsed_pkg::PH_BODY: begin
            if (b == qsed_pkg::CHAR_QUOTE) begin
               emit   = 1'b1;
               kind   = qsed_pkg::KIND_DONE;
               closed = 1'b1;
            end else if (b != qsed_pkg::CHAR_BSLASH) begin
               emit = 1'b1;
               val  = b;
            end
         end
         qsed_pkg::PH_ESC: begin
            if (!is_x && !is_oct_lead) begin
               emit = 1'b1;
               val  = qsed_pkg::simple_escape(b);
            end
         end
         qsed_pkg::PH_HEX1: begin
            if (!hex[4]) begin
               emit = 1'b1;
               val  = qsed_pkg::CHAR_LOWX;
            end
         end
         qsed_pkg::PH_HEX2: begin
            emit = 1'b1;
            val  = hex[4] ? {partial_ff, hex[3:0]} : {4'd0, partial_ff};
         end
         qsed_pkg::PH_OCT: begin
            emit = 1'b1;
            val  = is_oct ? {2'b00, partial_ff[2:0], b[2:0]} : {4'd0, partial_ff};
         end
         default: closed = 1'b1;
      endcase
      // text ended with the string still open
      if (req_data.in_last && !closed) begin
         emit = 1'b1;
         kind = qsed_pkg::KIND_EARLY;
         val  = 8'd0;
      end
   end

   assign result.out_byte = val;
   assign result.kind     = kind;

   // output register plus skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept && emit;
            out_data_in  = result;
         end
      end else if (accept && emit) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= qsed_pkg::PH_START;
         partial_ff    <= 4'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            partial_ff <= partial_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `QSED_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
                    "skid item without output item")
   `QSED_ASSERT_NEXT(a_stalled_emit_to_skid, clock, reset,
                     out_valid_ff && rsp_stall && accept && emit, skid_valid_ff,
                     "stalled result not kept in skid register")
   `QSED_ASSERT_NOW(a_status_byte_zero, clock, reset,
                    out_valid_ff && (out_data_ff.kind != qsed_pkg::KIND_DATA),
                    out_data_ff.out_byte == 8'd0, "status item carries nonzero byte")
   `QSED_ASSERT_NEXT(a_last_restarts, clock, reset, accept && req_data.in_last,
                     phase_ff == qsed_pkg::PH_START, "parser not restarted after last byte")

endmodule

`default_nettype wire
